// ----- rtl/mbe_pkg.sv -----
// Shared types and constants for the Mandelbrot escape-test unit.
package mbe_pkg;

  // Fixed widths of the request fields and configuration registers.
  localparam int IN_W      = 32;
  localparam int ITER_W    = 16;
  localparam int RADIUS_W  = 11;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 1'b1;

  // Register values after reset.
  localparam logic [ITER_W-1:0]   MAX_ITER_RST = 16'd1000;
  localparam logic [RADIUS_W-1:0] RADIUS_RST   = 11'd1000;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_THR,
    ST_THR_CAP,
    ST_PROD,
    ST_DIFF,
    ST_NEXTZ,
    ST_MAG,
    ST_SQ_A,
    ST_SQ_B,
    ST_TEST
  } state_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [1:0] {
    OP_RADIUS,
    OP_ZR_SQ,
    OP_ZI_SQ,
    OP_CROSS
  } op_sel_t;

  // Weight of a partial product before it joins the accumulator.
  typedef enum logic [1:0] {
    SH_NONE,
    SH_HALF,
    SH_HALF_DBL,
    SH_FULL
  } shift_t;

  // Control word from the sequencer to the datapath.
  typedef struct packed {
    op_sel_t op_sel;
    logic    a_hi;
    logic    b_hi;
    shift_t  shift;
    logic    acc_en;
    logic    acc_clr;
    logic    load;
    logic    cap_rsq;
    logic    cap_a;
    logic    cap_b;
    logic    do_diff;
    logic    do_nextz;
    logic    do_mag;
  } mbe_ctl_t;

endpackage

// ----- rtl/mandelbrot_escape_test_unit.sv -----
// Top level of the Mandelbrot escape-test unit: ports, registers and datapath.
//
// Usage: raise start with a point c on in_point_re / in_point_im (signed,
// FRAC_BITS fraction bits) while busy is low; the request is taken at that
// clock edge. Starting from z = 0 the unit repeats z = z*z + c and stops
// when re^2 + im^2 exceeds the square of the configured radius, or after
// max_iterations iterations. One result follows each request: out_valid is
// high for exactly one cycle with out_escaped beside it.
// Timing: each iteration runs on the single half-width multiplier (four
// partial products for re*im, three for each square, plus the update,
// magnitude and compare steps). busy falls in the strobe cycle, so a new
// request may be taken then; no new point is taken while one is in work.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0: iteration
// limit, 1: radius) at once; write only while busy is low.
// Reset: synchronous active-low rst_n returns to idle, with an iteration
// limit of 1000 and a radius of 1000. The receiver has no stall.
module mandelbrot_escape_test_unit import mbe_pkg::*; #(
  parameter int FRAC_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [IN_W-1:0] in_point_re,
  input  logic signed [IN_W-1:0] in_point_im,
  output logic                 out_valid,
  output logic                 out_escaped,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Magnitude width of z: bounded by radius^2 scaled, plus the point itself.
  localparam int MAG_BITS = 2 * RADIUS_W + FRAC_BITS;
  localparam int ZW       = ((MAG_BITS > IN_W - 1) ? MAG_BITS : IN_W - 1) + 1;
  localparam int HW       = (ZW + 1) / 2;
  localparam int ACC_W    = 2 * ZW;
  localparam int RSQ_W    = 2 * RADIUS_W;

  mbe_ctl_t ctl;
  logic     gt;

  logic [ITER_W-1:0]   max_iter_r;
  logic [ITER_W-1:0]   max_iter_nxt;
  logic [RADIUS_W-1:0] radius_r;
  logic [RADIUS_W-1:0] radius_nxt;

  logic signed [IN_W-1:0] cr_r, cr_nxt;
  logic signed [IN_W-1:0] ci_r, ci_nxt;
  logic signed [ZW:0]     zr_r, zr_nxt;
  logic signed [ZW:0]     zi_r, zi_nxt;
  logic [ZW-1:0]          ur_r, ur_nxt;
  logic [ZW-1:0]          ui_r, ui_nxt;
  logic [ACC_W-1:0]       a_r, a_nxt;
  logic [ACC_W-1:0]       b_r, b_nxt;
  logic [ACC_W-1:0]       dmag_r, dmag_nxt;
  logic                   dneg_r, dneg_nxt;
  logic [RSQ_W-1:0]       rsq_r, rsq_nxt;

  logic [ACC_W-1:0]   acc;
  logic [ZW-1:0]      sel_a;
  logic [ZW-1:0]      sel_b;
  logic [HW-1:0]      op_a;
  logic [HW-1:0]      op_b;
  logic [ACC_W:0]     a_minus_b;
  logic [ACC_W:0]     b_minus_a;
  logic [ACC_W:0]     mod_sum;
  logic [ACC_W:0]     thr_ext;
  logic [ZW-1:0]      quo_re;
  logic [ZW-1:0]      quo_im;
  logic signed [ZW:0] cr_ext;
  logic signed [ZW:0] ci_ext;
  logic signed [ZW:0] re_term;
  logic signed [ZW:0] im_term;
  logic               im_neg;
  logic signed [ZW:0] zr_neg;
  logic signed [ZW:0] zi_neg;

  // Configuration registers.
  always_comb begin
    max_iter_nxt = max_iter_r;
    radius_nxt   = radius_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_ITER: max_iter_nxt = cfg_wdata[ITER_W-1:0];
        CFG_RADIUS:   radius_nxt   = cfg_wdata[RADIUS_W-1:0];
        default:      max_iter_nxt = max_iter_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RST;
      radius_r   <= RADIUS_RST;
    end else begin
      max_iter_r <= max_iter_nxt;
      radius_r   <= radius_nxt;
    end
  end

  // Sequencer.
  mbe_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .max_iter    (max_iter_r),
    .gt          (gt),
    .busy        (busy),
    .ctl         (ctl),
    .out_valid   (out_valid),
    .out_escaped (out_escaped)
  );

  // Operand selection and half-word split for the shared multiplier.
  always_comb begin
    unique case (ctl.op_sel)
      OP_RADIUS: begin
        sel_a = ZW'(radius_r);
        sel_b = ZW'(radius_r);
      end
      OP_ZR_SQ: begin
        sel_a = ur_r;
        sel_b = ur_r;
      end
      OP_ZI_SQ: begin
        sel_a = ui_r;
        sel_b = ui_r;
      end
      default: begin
        sel_a = ur_r;
        sel_b = ui_r;
      end
    endcase
    op_a = ctl.a_hi ? HW'(sel_a[ZW-1:HW]) : sel_a[HW-1:0];
    op_b = ctl.b_hi ? HW'(sel_b[ZW-1:HW]) : sel_b[HW-1:0];
  end

  mbe_mac #(
    .HALF_W (HW),
    .ACC_W  (ACC_W)
  ) u_mac (
    .clk   (clk),
    .en    (ctl.acc_en),
    .clr   (ctl.acc_clr),
    .shift (ctl.shift),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc)
  );

  // Escape test: re^2 (held) plus im^2 (in the accumulator) against R^2.
  assign mod_sum = {1'b0, a_r} + {1'b0, acc};
  assign thr_ext = (ACC_W + 1)'(rsq_r) << (2 * FRAC_BITS);
  assign gt      = (mod_sum > thr_ext);

  // Difference of squares, kept as sign and magnitude.
  assign a_minus_b = {1'b0, a_r} - {1'b0, b_r};
  assign b_minus_a = {1'b0, b_r} - {1'b0, a_r};

  // Scaled terms of the update; both round toward zero.
  assign quo_re  = dmag_r[FRAC_BITS +: ZW];
  assign quo_im  = acc[FRAC_BITS - 1 +: ZW];
  assign cr_ext  = {{(ZW + 1 - IN_W){cr_r[IN_W-1]}}, cr_r};
  assign ci_ext  = {{(ZW + 1 - IN_W){ci_r[IN_W-1]}}, ci_r};
  assign re_term = $signed({1'b0, quo_re});
  assign im_term = $signed({1'b0, quo_im});
  assign im_neg  = zr_r[ZW] ^ zi_r[ZW];
  assign zr_neg  = -zr_r;
  assign zi_neg  = -zi_r;

  // Datapath register updates.
  always_comb begin
    cr_nxt   = cr_r;
    ci_nxt   = ci_r;
    zr_nxt   = zr_r;
    zi_nxt   = zi_r;
    ur_nxt   = ur_r;
    ui_nxt   = ui_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    dmag_nxt = dmag_r;
    dneg_nxt = dneg_r;
    rsq_nxt  = rsq_r;
    if (ctl.load) begin
      cr_nxt = in_point_re;
      ci_nxt = in_point_im;
      zr_nxt = '0;
      zi_nxt = '0;
      ur_nxt = '0;
      ui_nxt = '0;
      a_nxt  = '0;
      b_nxt  = '0;
    end
    if (ctl.cap_rsq) begin
      rsq_nxt = acc[RSQ_W-1:0];
    end
    if (ctl.cap_a) begin
      a_nxt = acc;
    end
    if (ctl.cap_b) begin
      b_nxt = acc;
    end
    if (ctl.do_diff) begin
      dneg_nxt = a_minus_b[ACC_W];
      dmag_nxt = a_minus_b[ACC_W] ? b_minus_a[ACC_W-1:0] : a_minus_b[ACC_W-1:0];
    end
    if (ctl.do_nextz) begin
      zr_nxt = dneg_r ? (cr_ext - re_term) : (cr_ext + re_term);
      zi_nxt = im_neg ? (ci_ext - im_term) : (ci_ext + im_term);
    end
    if (ctl.do_mag) begin
      ur_nxt = zr_r[ZW] ? zr_neg[ZW-1:0] : zr_r[ZW-1:0];
      ui_nxt = zi_r[ZW] ? zi_neg[ZW-1:0] : zi_r[ZW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    cr_r   <= cr_nxt;
    ci_r   <= ci_nxt;
    zr_r   <= zr_nxt;
    zi_r   <= zi_nxt;
    ur_r   <= ur_nxt;
    ui_r   <= ui_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    dmag_r <= dmag_nxt;
    dneg_r <= dneg_nxt;
    rsq_r  <= rsq_nxt;
  end

endmodule

// ----- rtl/mbe_mac.sv -----
// Shared half-width multiplier with a shifting accumulator for wide products.
module mbe_mac import mbe_pkg::*; #(
  parameter int HALF_W = 22,
  parameter int ACC_W  = 86
) (
  input  logic              clk,
  input  logic              en,
  input  logic              clr,
  input  shift_t            shift,
  input  logic [HALF_W-1:0] op_a,
  input  logic [HALF_W-1:0] op_b,
  output logic [ACC_W-1:0]  acc
);

  logic [2*HALF_W-1:0] pp;
  logic [ACC_W-1:0]    pp_ext;
  logic [ACC_W-1:0]    pp_sh;
  logic [ACC_W-1:0]    acc_r;
  logic [ACC_W-1:0]    acc_nxt;

  // One partial product per cycle; it joins the sum only while en is high.
  assign pp     = op_a * op_b;
  assign pp_ext = ACC_W'(pp);

  // Place the partial product at its weight.
  always_comb begin
    unique case (shift)
      SH_NONE:     pp_sh = pp_ext;
      SH_HALF:     pp_sh = pp_ext << HALF_W;
      SH_HALF_DBL: pp_sh = pp_ext << (HALF_W + 1);
      SH_FULL:     pp_sh = pp_ext << (2 * HALF_W);
      default:     pp_sh = pp_ext;
    endcase
  end

  // Start a new sum or add to the running one.
  always_comb begin
    acc_nxt = acc_r;
    if (en) begin
      acc_nxt = (clr ? '0 : acc_r) + pp_sh;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ----- rtl/mbe_ctrl.sv -----
// Sequencer that steps the shared multiplier through each escape iteration.
module mbe_ctrl import mbe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ITER_W-1:0] max_iter,
  input  logic              gt,
  output logic              busy,
  output mbe_ctl_t          ctl,
  output logic              out_valid,
  output logic              out_escaped
);

  state_t            state_r;
  state_t            state_nxt;
  logic [1:0]        step_r;
  logic [1:0]        step_nxt;
  logic [ITER_W-1:0] iter_r;
  logic [ITER_W-1:0] iter_nxt;
  logic              valid_r;
  logic              valid_nxt;
  logic              esc_r;
  logic              esc_nxt;
  logic              last_iter;

  assign last_iter = ((iter_r + ITER_W'(1)) == max_iter);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (start) state_nxt = ST_THR;
      ST_THR:     state_nxt = ST_THR_CAP;
      ST_THR_CAP: state_nxt = (max_iter == '0) ? ST_IDLE : ST_PROD;
      ST_PROD:    if (step_r == 2'd3) state_nxt = ST_DIFF;
      ST_DIFF:    state_nxt = ST_NEXTZ;
      ST_NEXTZ:   state_nxt = ST_MAG;
      ST_MAG:     state_nxt = ST_SQ_A;
      ST_SQ_A:    if (step_r == 2'd2) state_nxt = ST_SQ_B;
      ST_SQ_B:    if (step_r == 2'd2) state_nxt = ST_TEST;
      ST_TEST:    state_nxt = (gt || last_iter) ? ST_IDLE : ST_PROD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Partial-product step counter and iteration counter.
  always_comb begin
    step_nxt = 2'd0;
    iter_nxt = iter_r;
    unique case (state_r)
      ST_PROD:    step_nxt = step_r + 2'd1;
      ST_SQ_A,
      ST_SQ_B:    step_nxt = (step_r == 2'd2) ? 2'd0 : step_r + 2'd1;
      ST_THR_CAP: iter_nxt = '0;
      ST_TEST:    if (!gt && !last_iter) iter_nxt = iter_r + ITER_W'(1);
      default:    step_nxt = 2'd0;
    endcase
  end

  // Result strobe and flag.
  always_comb begin
    valid_nxt = ((state_r == ST_THR_CAP) && (max_iter == '0)) ||
                ((state_r == ST_TEST) && (gt || last_iter));
    esc_nxt   = valid_nxt ? ((state_r == ST_TEST) && gt) : esc_r;
  end

  // Control word for the datapath.
  always_comb begin
    ctl = '0;
    ctl.op_sel = OP_RADIUS;
    ctl.shift  = SH_NONE;
    unique case (state_r)
      ST_IDLE: begin
        ctl.load = start;
      end
      ST_THR: begin
        ctl.acc_en  = 1'b1;
        ctl.acc_clr = 1'b1;
      end
      ST_THR_CAP: begin
        ctl.cap_rsq = 1'b1;
      end
      ST_PROD: begin
        ctl.op_sel = OP_CROSS;
        ctl.acc_en = 1'b1;
        unique case (step_r)
          2'd0: ctl.acc_clr = 1'b1;
          2'd1: begin
            ctl.b_hi  = 1'b1;
            ctl.shift = SH_HALF;
          end
          2'd2: begin
            ctl.a_hi  = 1'b1;
            ctl.shift = SH_HALF;
          end
          default: begin
            ctl.a_hi  = 1'b1;
            ctl.b_hi  = 1'b1;
            ctl.shift = SH_FULL;
          end
        endcase
      end
      ST_DIFF:  ctl.do_diff  = 1'b1;
      ST_NEXTZ: ctl.do_nextz = 1'b1;
      ST_MAG:   ctl.do_mag   = 1'b1;
      ST_SQ_A, ST_SQ_B: begin
        ctl.op_sel = (state_r == ST_SQ_A) ? OP_ZR_SQ : OP_ZI_SQ;
        ctl.acc_en = 1'b1;
        unique case (step_r)
          2'd0: begin
            ctl.a_hi    = 1'b1;
            ctl.b_hi    = 1'b1;
            ctl.shift   = SH_FULL;
            ctl.acc_clr = 1'b1;
            ctl.cap_a   = (state_r == ST_SQ_B);
          end
          2'd1: begin
            ctl.a_hi  = 1'b1;
            ctl.shift = SH_HALF_DBL;
          end
          default: ctl.shift = SH_NONE;
        endcase
      end
      ST_TEST: ctl.cap_b = 1'b1;
      default: ctl.load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 2'd0;
      iter_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      iter_r  <= iter_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    esc_r <= esc_nxt;
  end

  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = valid_r;
  assign out_escaped = esc_r;

`ifndef SYNTHESIS
  // A result strobe lasts one cycle only.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r)
    else $error("result strobe held for more than one cycle");

  // An accepted request starts with the threshold product.
  a_start_thr: assert property (@(posedge clk) disable iff (!rst_n)
    (start && (state_r == ST_IDLE)) |=> (state_r == ST_THR))
    else $error("accepted request did not start the sequence");

  // No iteration runs past the limit.
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROD) |-> (iter_r < max_iter))
    else $error("iteration count reached the limit while iterating");

  // Results come only from the test step or an empty iteration limit.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (($past(state_r) == ST_TEST) || ($past(state_r) == ST_THR_CAP)))
    else $error("result strobe from an unexpected state");
`endif

endmodule
